// ===== hdl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants, types and the arctangent step table for the
// quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int IN_W        = 32;   // Q30 quaternion component
    localparam int Q_FRAC      = 30;
    localparam int PROD_W      = 34;   // product >> 30
    localparam int SUM_W       = 36;   // atan2 arguments
    localparam int S_W         = 32;   // clamped asin argument, [-2^30, 2^30]
    localparam int SQ_W        = 61;   // s*s and 2^60 - s*s
    localparam int ROOT_W      = 31;
    localparam int SQRT_STAGES = 31;   // one result bit per stage
    localparam int CORDIC_W    = 40;
    localparam int ANG_W       = 34;   // Q30 radians
    localparam int PITCH_W     = 15;
    localparam int TURN_W      = 16;
    localparam int PITCH_LIM   = 11521;
    localparam int TURN_LIM    = 23041;
    localparam int ATAN_TAB_LEN = 31;
    localparam int DEG_NUM     = 573;      // 57.3 * 10
    localparam int RECIP_10    = 1677722;  // ceil(2^24 / 10)
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;
    localparam int ROUND_HALF  = 5;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_DEF   = 7;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = 36'sd1073741824;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
    } turn_args_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [TURN_W-1:0]  roll;
        logic signed [TURN_W-1:0]  yaw;
        logic                      angles_valid;
    } out_item_t;

    // atan(2^-i) * 2^30, truncated toward zero
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] r;
        unique case (i)
            0:  r = 32'h3243F6A8;
            1:  r = 32'h1DAC6705;
            2:  r = 32'h0FADBAFC;
            3:  r = 32'h07F56EA6;
            4:  r = 32'h03FEAB76;
            5:  r = 32'h01FFD55B;
            6:  r = 32'h00FFFAAA;
            7:  r = 32'h007FFF55;
            8:  r = 32'h003FFFEA;
            9:  r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            23: r = 32'h0000007F;
            24: r = 32'h0000003F;
            25: r = 32'h0000001F;
            26: r = 32'h0000000F;
            27: r = 32'h00000007;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/q2e_in_if.sv =====
// ----------------------------------------------------------------------------
// q2e_in_if
// Quaternion request channel: valid/ready plus four Q30 components and flag.
// ----------------------------------------------------------------------------
interface q2e_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [q2e_pkg::IN_W-1:0]    q_w;
    logic signed [q2e_pkg::IN_W-1:0]    q_x;
    logic signed [q2e_pkg::IN_W-1:0]    q_y;
    logic signed [q2e_pkg::IN_W-1:0]    q_z;
    logic                               has_quat;

    modport source (output valid, q_w, q_x, q_y, q_z, has_quat, input ready);
    modport sink   (input valid, q_w, q_x, q_y, q_z, has_quat, output ready);
endinterface

// ===== hdl/q2e_out_if.sv =====
// ----------------------------------------------------------------------------
// q2e_out_if
// Euler angle result channel: valid/ready plus pitch, roll, yaw and flag.
// ----------------------------------------------------------------------------
interface q2e_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [q2e_pkg::PITCH_W-1:0]     pitch;
    logic signed [q2e_pkg::TURN_W-1:0]      roll;
    logic signed [q2e_pkg::TURN_W-1:0]      yaw;
    logic                                   angles_valid;

    modport source (output valid, pitch, roll, yaw, angles_valid, input ready);
    modport sink   (input valid, pitch, roll, yaw, angles_valid, output ready);
endinterface

// ===== hdl/q2e_sqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module q2e_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [q2e_pkg::SQ_W-1:0]          radicand,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic [q2e_pkg::ROOT_W-1:0]        root,
    output logic [SIDE_W-1:0]                 side_out
);
    localparam int N     = q2e_pkg::SQRT_STAGES;
    localparam int REM_W = q2e_pkg::SQ_W;
    localparam int RES_W = q2e_pkg::SQ_W + 1;

    logic [REM_W-1:0]  rem_reg  [0:N-1];
    logic [RES_W-1:0]  res_reg  [0:N-1];
    logic [SIDE_W-1:0] side_reg [0:N-1];
    logic              vld_reg  [0:N-1];

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (N - 1 - j));
        logic [REM_W-1:0]  rem_in;
        logic [RES_W-1:0]  res_in;
        logic [SIDE_W-1:0] side_src;
        logic              vld_in;
        logic [RES_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [RES_W-1:0]  res_next;

        if (j == 0) begin : g_first
            assign rem_in   = radicand;
            assign res_in   = '0;
            assign side_src = side_in;
            assign vld_in   = in_valid;
        end else begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign side_src = side_reg[j-1];
            assign vld_in   = vld_reg[j-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (RES_W'(rem_in) >= trial)
            begin
                rem_next = rem_in - trial[REM_W-1:0];
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                res_reg[j]  <= res_next;
                side_reg[j] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = res_reg[N-1][q2e_pkg::ROOT_W-1:0];
    assign side_out  = side_reg[N-1];

endmodule

// ===== hdl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2: quadrant pre-turn, then one stage per
// micro-rotation. Angle out in Q30 radians.
// ----------------------------------------------------------------------------
module q2e_cordic #(
    parameter int ITER   = q2e_pkg::CORDIC_ITERATIONS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [q2e_pkg::CORDIC_W-1:0]   x,
    input  logic signed [q2e_pkg::CORDIC_W-1:0]   y,
    input  logic [SIDE_W-1:0]                     side_in,
    output logic                                  out_valid,
    output logic signed [q2e_pkg::ANG_W-1:0]      angle,
    output logic [SIDE_W-1:0]                     side_out
);
    localparam int W  = q2e_pkg::CORDIC_W;
    localparam int ZW = q2e_pkg::ANG_W;
    localparam logic signed [ZW-1:0] HALF_PI = ZW'(q2e_pkg::atan_entry(0)) <<< 1;

    logic signed [W-1:0]  x_reg    [0:ITER];
    logic signed [W-1:0]  y_reg    [0:ITER];
    logic signed [ZW-1:0] z_reg    [0:ITER];
    logic                 zero_reg [0:ITER];
    logic [SIDE_W-1:0]    side_reg [0:ITER];
    logic                 vld_reg  [0:ITER];

    logic signed [W-1:0]  x_next;
    logic signed [W-1:0]  y_next;
    logic signed [ZW-1:0] z_next;

    // quadrant pre-turn by +-pi/2 for left half-plane vectors
    always_comb
    begin
        if (x < 0)
        begin
            if (y >= 0)
            begin
                x_next = y;
                y_next = -x;
                z_next = HALF_PI;
            end
            else
            begin
                x_next = -y;
                y_next = x;
                z_next = -HALF_PI;
            end
        end
        else
        begin
            x_next = x;
            y_next = y;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (y == 0) && (x >= 0);
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_iter
        localparam logic signed [ZW-1:0] STEP = ZW'(q2e_pkg::atan_entry(i));
        logic signed [W-1:0]  dx;
        logic signed [W-1:0]  dy;
        logic signed [W-1:0]  xs_next;
        logic signed [W-1:0]  ys_next;
        logic signed [ZW-1:0] zs_next;

        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                xs_next = x_reg[i] + dy;
                ys_next = y_reg[i] - dx;
                zs_next = z_reg[i] + STEP;
            end
            else
            begin
                xs_next = x_reg[i] - dy;
                ys_next = y_reg[i] + dx;
                zs_next = z_reg[i] - STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= xs_next;
                y_reg[i+1]    <= ys_next;
                z_reg[i+1]    <= zs_next;
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[ITER];
    assign angle     = zero_reg[ITER] ? '0 : z_reg[ITER];
    assign side_out  = side_reg[ITER];

endmodule

// ===== hdl/q2e_scale.sv =====
// ----------------------------------------------------------------------------
// q2e_scale
// Radians (Q30) to 1/2^FRAC degree: magnitude, times 573, divide by 10*2^30
// with half-up rounding via reciprocal multiply, saturate, restore sign.
// ----------------------------------------------------------------------------
module q2e_scale #(
    parameter int FRAC   = q2e_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_W  = q2e_pkg::TURN_W,
    parameter int LIM    = q2e_pkg::TURN_LIM,
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [q2e_pkg::ANG_W-1:0]    angle,
    input  logic [SIDE_W-1:0]                   side_in,
    output logic                                out_valid,
    output logic signed [OUT_W-1:0]             units,
    output logic [SIDE_W-1:0]                   side_out
);
    localparam int ZW  = q2e_pkg::ANG_W;
    localparam int P_W = ZW + 10;
    localparam int T_W = P_W - q2e_pkg::Q_FRAC + FRAC;
    localparam int V_W = T_W + 1;
    localparam int R_W = V_W + q2e_pkg::RECIP_W;
    localparam int Q_W = R_W - q2e_pkg::RECIP_SHIFT;

    logic [ZW-1:0]           mag_reg;
    logic [P_W-1:0]          prod_reg;
    logic [R_W-1:0]          recip_reg;
    logic signed [OUT_W-1:0] units_reg;
    logic                    sgn_reg  [0:2];
    logic [SIDE_W-1:0]       side_reg [0:3];
    logic                    vld_reg  [0:3];

    logic [ZW-1:0]           mag_next;
    logic [P_W-1:0]          prod_next;
    logic [T_W-1:0]          whole;
    logic [R_W-1:0]          recip_next;
    logic [Q_W-1:0]          quot;
    logic [Q_W-1:0]          quot_sat;
    logic signed [OUT_W-1:0] units_next;

    always_comb
    begin
        mag_next   = angle[ZW-1] ? ZW'(-angle) : ZW'(angle);
        prod_next  = P_W'(mag_reg) * P_W'(q2e_pkg::DEG_NUM);
        whole      = prod_reg[P_W-1:q2e_pkg::Q_FRAC-FRAC];
        recip_next = R_W'(V_W'(whole) + V_W'(q2e_pkg::ROUND_HALF))
                     * R_W'(q2e_pkg::RECIP_10);
        quot       = recip_reg[R_W-1:q2e_pkg::RECIP_SHIFT];
        quot_sat   = (quot > Q_W'(LIM)) ? Q_W'(LIM) : quot;
        units_next = sgn_reg[2] ? -OUT_W'(quot_sat) : OUT_W'(quot_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
            vld_reg[2] <= 1'b0;
            vld_reg[3] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
            vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag_next;
            sgn_reg[0]  <= angle[ZW-1];
            side_reg[0] <= side_in;
            prod_reg    <= prod_next;
            sgn_reg[1]  <= sgn_reg[0];
            side_reg[1] <= side_reg[0];
            recip_reg   <= recip_next;
            sgn_reg[2]  <= sgn_reg[1];
            side_reg[2] <= side_reg[1];
            units_reg   <= units_next;
            side_reg[3] <= side_reg[2];
        end
    end

    assign out_valid = vld_reg[3];
    assign units     = units_reg;
    assign side_out  = side_reg[3];

endmodule

// ===== hdl/quaternion_to_euler_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Pipeline: products, sums, square, radicand, the 31-stage square root,
// the CORDIC, the scaler and the result register.
// Throughput: one request per cycle; the whole pipe holds only while the
// output skid register is occupied.
// Reset (rst_n, async low) clears all valid bits; no results are pending.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit #(
    parameter int CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = q2e_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    q2e_in_if.sink      quat,
    q2e_out_if.source   angles
);
    localparam int PW  = q2e_pkg::PROD_W;
    localparam int SW  = q2e_pkg::SUM_W;
    localparam int DLY = 2 + q2e_pkg::SQRT_STAGES;

    function automatic logic signed [PW-1:0] mulq(
        input logic signed [q2e_pkg::IN_W-1:0] a,
        input logic signed [q2e_pkg::IN_W-1:0] b
    );
        logic signed [2*q2e_pkg::IN_W-1:0] p;
        p = a * b;
        return p[2*q2e_pkg::IN_W-1:q2e_pkg::Q_FRAC];
    endfunction

    logic en;
    logic main_vld_reg, main_vld_next;
    logic skid_vld_reg, skid_vld_next;
    q2e_pkg::out_item_t main_reg, main_next;
    q2e_pkg::out_item_t skid_reg, skid_next;

    // stage 1: products
    logic signed [PW-1:0] p_wy_reg, p_xz_reg, p_yz_reg, p_wx_reg, p_xx_reg;
    logic signed [PW-1:0] p_yy_reg, p_wz_reg, p_xy_reg, p_ww_reg, p_zz_reg;
    logic s1_has_reg, s1_vld_reg;

    // stage 2: sums
    logic signed [SW-1:0] s_full;
    logic signed [q2e_pkg::S_W-1:0] s2_s_reg, s2_s_next;
    q2e_pkg::turn_args_t s2_args_reg, s2_args_next;
    logic s2_has_reg, s2_vld_reg;

    // stage 3/4: square, radicand
    logic signed [2*q2e_pkg::S_W-1:0] sq_full;
    logic [q2e_pkg::SQ_W-1:0] s3_sq_reg, s4_rad_reg;
    logic signed [q2e_pkg::S_W-1:0] s3_s_reg, s4_s_reg;
    logic s3_has_reg, s3_vld_reg, s4_has_reg, s4_vld_reg;

    q2e_pkg::turn_args_t args_dly_reg [0:DLY-1];

    logic sq_vld;
    logic [q2e_pkg::ROOT_W-1:0] root;
    logic [q2e_pkg::S_W:0] sq_side;

    logic pc_vld, rc_vld, yc_vld;
    logic signed [q2e_pkg::ANG_W-1:0] p_ang, r_ang, y_ang;
    logic pc_has, rc_has, yc_has;

    logic ps_vld, rs_vld, ys_vld;
    logic signed [q2e_pkg::PITCH_W-1:0] p_units;
    logic signed [q2e_pkg::TURN_W-1:0]  r_units, y_units;
    logic ps_has, rs_has, ys_has;

    logic pop, push;
    q2e_pkg::out_item_t item;

    assign en         = !skid_vld_reg;
    assign quat.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= quat.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_comb
    begin
        s_full = (SW'(p_wy_reg) - SW'(p_xz_reg)) <<< 1;
        if (s_full > q2e_pkg::ONE_Q30)
            s2_s_next = q2e_pkg::S_W'(q2e_pkg::ONE_Q30);
        else if (s_full < -q2e_pkg::ONE_Q30)
            s2_s_next = q2e_pkg::S_W'(-q2e_pkg::ONE_Q30);
        else
            s2_s_next = q2e_pkg::S_W'(s_full);
        s2_args_next.roll_y = (SW'(p_yz_reg) + SW'(p_wx_reg)) <<< 1;
        s2_args_next.roll_x = q2e_pkg::ONE_Q30 - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
        s2_args_next.yaw_y  = (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
        s2_args_next.yaw_x  = SW'(p_ww_reg) + SW'(p_xx_reg)
                              - SW'(p_yy_reg) - SW'(p_zz_reg);
        sq_full = s2_s_reg * s2_s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wy_reg   <= mulq(quat.q_w, quat.q_y);
            p_xz_reg   <= mulq(quat.q_x, quat.q_z);
            p_yz_reg   <= mulq(quat.q_y, quat.q_z);
            p_wx_reg   <= mulq(quat.q_w, quat.q_x);
            p_xx_reg   <= mulq(quat.q_x, quat.q_x);
            p_yy_reg   <= mulq(quat.q_y, quat.q_y);
            p_wz_reg   <= mulq(quat.q_w, quat.q_z);
            p_xy_reg   <= mulq(quat.q_x, quat.q_y);
            p_ww_reg   <= mulq(quat.q_w, quat.q_w);
            p_zz_reg   <= mulq(quat.q_z, quat.q_z);
            s1_has_reg <= quat.has_quat;

            s2_s_reg    <= s2_s_next;
            s2_args_reg <= s2_args_next;
            s2_has_reg  <= s1_has_reg;

            s3_sq_reg  <= sq_full[q2e_pkg::SQ_W-1:0];
            s3_s_reg   <= s2_s_reg;
            s3_has_reg <= s2_has_reg;

            s4_rad_reg <= (q2e_pkg::SQ_W'(1) << (2 * q2e_pkg::Q_FRAC)) - s3_sq_reg;
            s4_s_reg   <= s3_s_reg;
            s4_has_reg <= s3_has_reg;

            // hold roll/yaw arguments until the pitch root is ready
            args_dly_reg[0] <= s2_args_reg;
            for (int k = 1; k < DLY; k++)
                args_dly_reg[k] <= args_dly_reg[k-1];
        end
    end

    q2e_sqrt #(.SIDE_W(q2e_pkg::S_W + 1)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s4_vld_reg), .radicand(s4_rad_reg),
        .side_in({s4_has_reg, s4_s_reg}),
        .out_valid(sq_vld), .root(root), .side_out(sq_side)
    );

    q2e_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W(1)) u_cordic_pitch (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_vld),
        .x(q2e_pkg::CORDIC_W'($signed({1'b0, root}))),
        .y(q2e_pkg::CORDIC_W'($signed(sq_side[q2e_pkg::S_W-1:0]))),
        .side_in(sq_side[q2e_pkg::S_W]),
        .out_valid(pc_vld), .angle(p_ang), .side_out(pc_has)
    );

    q2e_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W(1)) u_cordic_roll (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_vld),
        .x(q2e_pkg::CORDIC_W'(args_dly_reg[DLY-1].roll_x)),
        .y(q2e_pkg::CORDIC_W'(args_dly_reg[DLY-1].roll_y)),
        .side_in(sq_side[q2e_pkg::S_W]),
        .out_valid(rc_vld), .angle(r_ang), .side_out(rc_has)
    );

    q2e_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W(1)) u_cordic_yaw (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_vld),
        .x(q2e_pkg::CORDIC_W'(args_dly_reg[DLY-1].yaw_x)),
        .y(q2e_pkg::CORDIC_W'(args_dly_reg[DLY-1].yaw_y)),
        .side_in(sq_side[q2e_pkg::S_W]),
        .out_valid(yc_vld), .angle(y_ang), .side_out(yc_has)
    );

    q2e_scale #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(q2e_pkg::PITCH_W),
                .LIM(q2e_pkg::PITCH_LIM), .SIDE_W(1)) u_scale_pitch (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pc_vld),
        .angle(p_ang), .side_in(pc_has),
        .out_valid(ps_vld), .units(p_units), .side_out(ps_has)
    );

    q2e_scale #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(q2e_pkg::TURN_W),
                .LIM(q2e_pkg::TURN_LIM), .SIDE_W(1)) u_scale_roll (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(rc_vld),
        .angle(r_ang), .side_in(rc_has),
        .out_valid(rs_vld), .units(r_units), .side_out(rs_has)
    );

    q2e_scale #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(q2e_pkg::TURN_W),
                .LIM(q2e_pkg::TURN_LIM), .SIDE_W(1)) u_scale_yaw (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(yc_vld),
        .angle(y_ang), .side_in(yc_has),
        .out_valid(ys_vld), .units(y_units), .side_out(ys_has)
    );

    // drop angles to zero when no quaternion was present
    always_comb
    begin
        item.pitch        = ps_has ? p_units : '0;
        item.roll         = ps_has ? r_units : '0;
        item.yaw          = ps_has ? y_units : '0;
        item.angles_valid = ps_has;
        push = en && ps_vld;
        pop  = main_vld_reg && angles.ready;

        main_vld_next = main_vld_reg;
        skid_vld_next = skid_vld_reg;
        main_next     = main_reg;
        skid_next     = skid_reg;
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                main_next     = skid_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_vld_reg || pop)
            begin
                main_next     = item;
                main_vld_next = 1'b1;
            end
            else
            begin
                skid_next     = item;
                skid_vld_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            main_vld_reg <= main_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign angles.valid        = main_vld_reg;
    assign angles.pitch        = main_reg.pitch;
    assign angles.roll         = main_reg.roll;
    assign angles.yaw          = main_reg.yaw;
    assign angles.angles_valid = main_reg.angles_valid;

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> main_vld_reg)
        else $error("skid register holds a result while output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ps_vld == rs_vld) && (ps_vld == ys_vld)
        && (!ps_vld || ((ps_has == rs_has) && (ps_has == ys_has))))
        else $error("pitch, roll and yaw lanes out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (main_vld_reg && !main_reg.angles_valid) |->
        (main_reg.pitch == 0 && main_reg.roll == 0 && main_reg.yaw == 0))
        else $error("nonzero angles without a quaternion");

    assert property (@(posedge clk) disable iff (!rst_n)
        main_vld_reg |->
        (main_reg.pitch <= q2e_pkg::PITCH_LIM && main_reg.pitch >= -q2e_pkg::PITCH_LIM))
        else $error("pitch beyond saturation limit");

endmodule

// ===== tb/quaternion_to_euler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit_tb
// Drives random and corner-case quaternions through the Euler angle pipeline
// and checks every result against a fixed-point predictor of the same math.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_to_euler_unit_tb;

    localparam int ITERS        = q2e_pkg::CORDIC_ITERATIONS_DEF;
    localparam int FRAC_BITS    = q2e_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int LATENCY      = 41 + ITERS;
    localparam int HOLD_OFF_LEN = 300;

    typedef struct {
        logic signed [31:0] w, x, y, z;
        logic               present;
    } quat_req_t;

    typedef struct {
        logic signed [q2e_pkg::PITCH_W-1:0] pitch;
        logic signed [q2e_pkg::TURN_W-1:0]  roll;
        logic signed [q2e_pkg::TURN_W-1:0]  yaw;
        logic                               ok;
    } euler_t;

    logic clk;
    logic rst_n;

    q2e_in_if  quat();
    q2e_out_if angles();

    quaternion_to_euler_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .quat   (quat),
        .angles (angles)
    );

    quat_req_t pending_reqs[$];
    euler_t    expected_angles[$];
    int        src_idle_pct;
    int        dst_idle_pct;
    bit        hold_off_req;
    bit        hold_off_active;
    int        mismatches;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor division by 2^n
    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shift(a * b, 30);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint vy, longint vx);
        longint ang;
        longint tmp;
        longint dx;
        longint dy;
        ang = 0;
        if (vy == 0 && vx >= 0)
            return 0;
        if (vx < 0)
        begin
            tmp = vx;
            if (vy >= 0)
            begin
                vx = vy;
                vy = -tmp;
                ang = 2 * longint'(q2e_pkg::atan_entry(0));
            end
            else
            begin
                vx = -vy;
                vy = tmp;
                ang = -2 * longint'(q2e_pkg::atan_entry(0));
            end
        end
        for (int i = 0; i < ITERS && i < q2e_pkg::ATAN_TAB_LEN; i++)
        begin
            dx = floor_shift(vx, i);
            dy = floor_shift(vy, i);
            if (vy > 0)
            begin
                vx += dy;
                vy -= dx;
                ang += longint'(q2e_pkg::atan_entry(i));
            end
            else
            begin
                vx -= dy;
                vy += dx;
                ang -= longint'(q2e_pkg::atan_entry(i));
            end
        end
        return ang;
    endfunction

    function automatic longint rad_to_units(longint ang, longint lim);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        mag = (ang < 0) ? -ang : ang;
        den = 64'd10 << 30;
        q = (((mag * q2e_pkg::DEG_NUM) << FRAC_BITS) + den / 2) / den;
        if (q > lim)
            q = lim;
        return (ang < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic euler_t predict_euler(quat_req_t r);
        euler_t e;
        longint w, x, y, z, s, c, ry, rx, yy, yx;
        w = r.w;
        x = r.x;
        y = r.y;
        z = r.z;
        e = '{default: '0};
        if (!r.present)
            return e;
        s = 2 * (q30_mul(w, y) - q30_mul(x, z));
        if (s > (64'sd1 << 30))
            s = 64'sd1 << 30;
        if (s < -(64'sd1 << 30))
            s = -(64'sd1 << 30);
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        ry = 2 * (q30_mul(y, z) + q30_mul(w, x));
        rx = (64'sd1 << 30) - 2 * (q30_mul(x, x) + q30_mul(y, y));
        yy = 2 * (q30_mul(w, z) + q30_mul(x, y));
        yx = q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y) - q30_mul(z, z);
        e.pitch = q2e_pkg::PITCH_W'(rad_to_units(vector_angle(s, c), q2e_pkg::PITCH_LIM));
        e.roll  = q2e_pkg::TURN_W'(rad_to_units(vector_angle(ry, rx), q2e_pkg::TURN_LIM));
        e.yaw   = q2e_pkg::TURN_W'(rad_to_units(vector_angle(yy, yx), q2e_pkg::TURN_LIM));
        e.ok    = 1'b1;
        return e;
    endfunction

    function automatic logic signed [31:0] rand_component();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh40000000;
            3: return -32'sh40000000;
            4: return 32'sd0;
            5, 6: return $urandom;
            default: return $signed(32'($urandom_range(0, 32'h80000000))) - 32'sh40000000;
        endcase
    endfunction

    // roughly unit quaternion with random direction
    function automatic quat_req_t rand_unit_quat();
        quat_req_t r;
        real a, b, c, d, n;
        a = real'($signed($urandom)) / 2147483648.0;
        b = real'($signed($urandom)) / 2147483648.0;
        c = real'($signed($urandom)) / 2147483648.0;
        d = real'($signed($urandom)) / 2147483648.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
        r.w = $rtoi(a / n * 1073741823.0);
        r.x = $rtoi(b / n * 1073741823.0);
        r.y = $rtoi(c / n * 1073741823.0);
        r.z = $rtoi(d / n * 1073741823.0);
        r.present = 1'b1;
        return r;
    endfunction

    task automatic add_req(logic signed [31:0] w, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z, logic p);
        quat_req_t r;
        r.w = w;
        r.x = x;
        r.y = y;
        r.z = z;
        r.present = p;
        pending_reqs.push_back(r);
    endtask

    task automatic add_random(int n);
        quat_req_t r;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r.w = rand_component();
                r.x = rand_component();
                r.y = rand_component();
                r.z = rand_component();
                r.present = $urandom_range(0, 4) != 0;
            end
            else
            begin
                r = rand_unit_quat();
                if ($urandom_range(0, 15) == 0)
                    r.present = 1'b0;
            end
            pending_reqs.push_back(r);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_angles.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat.valid    <= 1'b0;
            quat.q_w      <= '0;
            quat.q_x      <= '0;
            quat.q_y      <= '0;
            quat.q_z      <= '0;
            quat.has_quat <= 1'b0;
        end
        else
        begin
            if (quat.valid && quat.ready)
            begin
                expected_angles.push_back(predict_euler(pending_reqs.pop_front()));
            end
            if (!quat.valid || quat.ready)
            begin
                // the head of the queue is the next request to offer
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    quat.valid    <= 1'b1;
                    quat.q_w      <= pending_reqs[0].w;
                    quat.q_x      <= pending_reqs[0].x;
                    quat.q_y      <= pending_reqs[0].y;
                    quat.q_z      <= pending_reqs[0].z;
                    quat.has_quat <= pending_reqs[0].present;
                end
                else
                    quat.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted in cycles
    initial
    begin
        int held;
        hold_off_active = 1'b0;
        wait (hold_off_req);
        @(posedge clk);
        hold_off_active <= 1'b1;
        held = 0;
        while (held < HOLD_OFF_LEN)
        begin
            @(posedge clk);
            held++;
        end
        hold_off_active <= 1'b0;
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        euler_t e;
        if (!rst_n)
            angles.ready <= 1'b0;
        else
        begin
            if (angles.valid && angles.ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result pitch=%0d roll=%0d yaw=%0d",
                                 angles.pitch, angles.roll, angles.yaw);
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (angles.pitch !== e.pitch || angles.roll !== e.roll ||
                        angles.yaw !== e.yaw || angles.angles_valid !== e.ok)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                     e.pitch, e.roll, e.yaw, e.ok, angles.pitch,
                                     angles.roll, angles.yaw, angles.angles_valid);
                    end
                end
            end
            if (hold_off_active)
                angles.ready <= 1'b0;
            else
                angles.ready <= $urandom_range(0, 99) >= dst_idle_pct;
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        src_idle_pct = 33;
        dst_idle_pct = 87;
        hold_off_req = 1'b0;
        mismatches = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // corner cases: identity, absent flag, poles, half turns, extremes
        add_req(32'sh40000000, 0, 0, 0, 1'b1);
        add_req(32'sh12345678, -32'sd5, 32'sd77, 32'sh7FFFFFFF, 1'b0);
        add_req(0, 0, 0, 0, 1'b1);
        add_req(32'sh2D413CCD, 0, 32'sh2D413CCD, 0, 1'b1);
        add_req(32'sh2D413CCD, 0, -32'sh2D413CCD, 0, 1'b1);
        add_req(0, 32'sh40000000, 0, 0, 1'b1);
        add_req(0, 0, 0, 32'sh40000000, 1'b1);
        add_req(0, 0, 32'sh40000000, 0, 1'b1);
        add_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
        add_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
        add_req(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
        add_req(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        add_req(-32'sh40000000, 0, 0, 0, 1'b1);
        add_req(32'sh2D413CCD, 32'sh2D413CCD, 0, 0, 1'b1);
        add_req(32'sh2D413CCD, 0, 0, -32'sh2D413CCD, 1'b1);
        add_req(32'sd1, -32'sd1, 32'sd1, -32'sd1, 1'b1);
        add_req(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        add_random(550);
        drain();

        // long receiver hold-off while the sender keeps pushing
        src_idle_pct = 0;
        hold_off_req = 1'b1;
        add_random(150);
        drain();

        src_idle_pct = 87;
        dst_idle_pct = 33;
        add_random(500);
        drain();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        add_random(500);
        drain();

        wait_cycles = 0;
        while (wait_cycles < LATENCY + 20)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
